// ----- rtl/sci_pkg.sv -----
// ----------------------------------------------------------------------------
// sci_pkg: shared types and constants
// Request kinds, register word map and the result record of the set/clear
// interrupt controller.
// ----------------------------------------------------------------------------
package sci_pkg;

    localparam int unsigned NUM_SOURCES = 32;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned ADDR_W      = 7;
    localparam int unsigned SEL_W       = 5;
    localparam int unsigned LINE_W      = $clog2(NUM_SOURCES);

    // Request kinds
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LINE  = 2'd2;

    // Register word indexes
    localparam logic [ADDR_W-1:0] ADDR_MASKED_STATUS = 7'h00;
    localparam logic [ADDR_W-1:0] ADDR_RAW_STATUS    = 7'h01;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE_SET    = 7'h02;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE_CLEAR  = 7'h03;
    localparam logic [ADDR_W-1:0] ADDR_SOFT_IRQ      = 7'h04;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_STATUS    = 7'h40;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_RAW       = 7'h41;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_EN_SET    = 7'h42;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_EN_CLEAR  = 7'h43;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_SELECT    = 7'h7F;

    // Raw status bit shared with the software interrupt
    localparam int unsigned        SOFT_IRQ_BIT = 1;
    // FIQ select value that routes the software interrupt to the FIQ
    localparam logic [SEL_W-1:0]   FIQ_SEL_SOFT = 5'd1;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              fiq;
    } sci_result_t;

endpackage

// ----- rtl/set_clear_interrupt_controller.sv -----
// ----------------------------------------------------------------------------
// set_clear_interrupt_controller: 32-source IRQ/FIQ controller
// Bus reads, bus writes and source line changes enter on one request channel;
// each request yields one result with read data and both interrupt levels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request per cycle while s_ready is high: s_func
//   selects a bus read, a bus write (s_word_addr, s_write_data) or a line
//   level change (s_line_index, s_line_level). Function code 3 changes nothing.
//   m_* channel returns exactly one result per request, in order:
//   m_read_data (zero unless a read), m_irq_out and m_fiq_out showing the
//   controller state right after that request.
//   m_valid rises in the cycle after acceptance. Throughput is one
//   request per cycle while m_ready keeps up; the state update and result
//   decode are combinational between the request and the output register.
//   When the receiver stalls, the output register holds its result and
//   s_ready stays high only if the register is being emptied the same cycle.
//   Reset (aresetn low, synchronous) clears all status, enables, the FIQ
//   select and the output valid.
// ----------------------------------------------------------------------------
module set_clear_interrupt_controller
    import sci_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [ADDR_W-1:0] s_word_addr,
    input  logic [DATA_W-1:0] s_write_data,
    input  logic [LINE_W-1:0] s_line_index,
    input  logic              s_line_level,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic              m_irq_out,
    output logic              m_fiq_out
);

    logic        accept;
    logic        m_valid_reg;
    sci_result_t result;
    sci_result_t result_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sci_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (accept),
        .func       (s_func),
        .word_addr  (s_word_addr),
        .write_data (s_write_data),
        .line_index (s_line_index),
        .line_level (s_line_level),
        .result     (result)
    );

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = result_reg.read_data;
    assign m_irq_out   = result_reg.irq;
    assign m_fiq_out   = result_reg.fiq;

endmodule

// ----- rtl/sci_regs.sv -----
// ----------------------------------------------------------------------------
// sci_regs: interrupt controller state and request decode
// Holds raw status, enables and the FIQ path; applies one request per cycle
// while update is high and forms the read data and interrupt levels for it.
// ----------------------------------------------------------------------------
module sci_regs
    import sci_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              update,
    input  logic [1:0]        func,
    input  logic [ADDR_W-1:0] word_addr,
    input  logic [DATA_W-1:0] write_data,
    input  logic [LINE_W-1:0] line_index,
    input  logic              line_level,
    output sci_result_t       result
);

    logic [DATA_W-1:0] raw_reg,  raw_next;
    logic [DATA_W-1:0] en_reg,   en_next;
    logic              fpend_reg, fpend_next;
    logic              fen_reg,   fen_next;
    logic [SEL_W-1:0]  fsel_reg,  fsel_next;
    logic [DATA_W-1:0] rd_data;

    // Read mux against current state
    always_comb begin
        case (word_addr)
            ADDR_MASKED_STATUS: rd_data = raw_reg & en_reg;
            ADDR_RAW_STATUS:    rd_data = raw_reg;
            ADDR_ENABLE_SET:    rd_data = en_reg;
            ADDR_FIQ_STATUS:    rd_data = {{(DATA_W-1){1'b0}}, fen_reg & fpend_reg};
            ADDR_FIQ_RAW:       rd_data = {{(DATA_W-1){1'b0}}, fpend_reg};
            ADDR_FIQ_EN_SET:    rd_data = {{(DATA_W-1){1'b0}}, fen_reg};
            ADDR_FIQ_SELECT:    rd_data = {{(DATA_W-SEL_W){1'b0}}, fsel_reg};
            default:            rd_data = '0;
        endcase
    end

    // Next state for writes and line changes
    always_comb begin
        raw_next   = raw_reg;
        en_next    = en_reg;
        fpend_next = fpend_reg;
        fen_next   = fen_reg;
        fsel_next  = fsel_reg;
        case (func)
            FUNC_WRITE: begin
                case (word_addr)
                    ADDR_ENABLE_SET: begin
                        en_next = en_reg | write_data;
                    end
                    ADDR_ENABLE_CLEAR: begin
                        // dropping enables also drops their raw bits and the soft bit
                        en_next  = en_reg & ~write_data;
                        raw_next = raw_reg & en_next;
                        raw_next[SOFT_IRQ_BIT] = 1'b0;
                    end
                    ADDR_SOFT_IRQ: begin
                        if (write_data[0]) begin
                            raw_next[SOFT_IRQ_BIT] = 1'b1;
                            if (fsel_reg == FIQ_SEL_SOFT) begin
                                fpend_next = 1'b1;
                            end
                        end
                    end
                    ADDR_FIQ_EN_SET: begin
                        fen_next = fen_reg | write_data[0];
                    end
                    ADDR_FIQ_EN_CLEAR: begin
                        fen_next = fen_reg & ~write_data[0];
                        if (fsel_reg == FIQ_SEL_SOFT) begin
                            fpend_next = 1'b0;
                        end
                    end
                    ADDR_FIQ_SELECT: begin
                        fsel_next = write_data[SEL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            FUNC_LINE: begin
                raw_next[line_index] = line_level;
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after the request
    always_comb begin
        result.read_data = (func == FUNC_READ) ? rd_data : '0;
        result.irq       = |(raw_next & en_next);
        result.fiq       = fen_next & fpend_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg   <= '0;
            en_reg    <= '0;
            fpend_reg <= 1'b0;
            fen_reg   <= 1'b0;
            fsel_reg  <= '0;
        end else if (update) begin
            raw_reg   <= raw_next;
            en_reg    <= en_next;
            fpend_reg <= fpend_next;
            fen_reg   <= fen_next;
            fsel_reg  <= fsel_next;
        end
    end

endmodule
